// ===== rtl/rtc_alarm_snooze_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RTC_ALARM_SNOOZE_DEFINES_SVH
`define RTC_ALARM_SNOOZE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RTCAS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define RTCAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check what reset leaves behind in the cycle after it.
`define RTCAS_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rtcas_pkg.sv =====
package rtcas_pkg;

   // Decoded command
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SET    = 2'd1,
      OP_SNOOZE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_TICKS  = 2'd0;
   localparam logic [1:0] CSR_ALARM  = 2'd1;
   localparam logic [1:0] CSR_ENABLE = 2'd2;

   localparam logic [16:0] SECS_PER_DAY = 17'd86400;
   localparam logic [16:0] LAST_SECOND  = 17'd86399;
   localparam logic [15:0] TICKS_RESET  = 16'd1000;

   localparam int QUEUE_DEPTH = 2;

   // Classified command as it sits in the queue
   typedef struct packed {
      op_type     op;
      logic [5:0] hour_raw;
      logic [6:0] minute_raw;
      logic [6:0] second_raw;
      logic [7:0] snooze_minutes;
   } item_type;

   // One result transfer
   typedef struct packed {
      logic [1:0] h_tens;
      logic [3:0] h_ones;
      logic [2:0] m_tens;
      logic [3:0] m_ones;
      logic [2:0] s_tens;
      logic [3:0] s_ones;
      logic       time_valid;
      logic       alarm_fired;
   } result_type;

   // Tens digit of a value below 64
   function automatic logic [2:0] tens_of(input logic [5:0] v);
      logic [2:0] t;
      priority if (v >= 6'd60) t = 3'd6;
      else if (v >= 6'd50) t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else t = 3'd0;
      return t;
   endfunction

   // Ones digit of a value below 64
   function automatic logic [3:0] ones_of(input logic [5:0] v);
      logic [5:0] r;
      r = v - 6'(tens_of(v)) * 6'd10;
      return r[3:0];
   endfunction

endpackage

// ===== rtl/rtcas_front.sv =====
module rtcas_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [1:0]         req_set_hour_tens,
   input  logic [3:0]         req_set_hour_ones,
   input  logic [2:0]         req_set_minute_tens,
   input  logic [3:0]         req_set_minute_ones,
   input  logic [2:0]         req_set_second_tens,
   input  logic [3:0]         req_set_second_ones,
   input  logic [7:0]         req_snooze_minutes,
   output logic               head_valid,
   output rtcas_pkg::item_type head,
   input  logic               pop
);
   import rtcas_pkg::*;

   item_type   item;
   item_type   queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // Classify the command and weight the set-time digits
   always_comb begin
      item.op             = op_type'(req_cmd);
      item.hour_raw       = 6'(req_set_hour_tens) * 6'd10 + 6'(req_set_hour_ones);
      item.minute_raw     = 7'(req_set_minute_tens) * 7'd10 + 7'(req_set_minute_ones);
      item.second_raw     = 7'(req_set_second_tens) * 7'd10 + 7'(req_set_second_ones);
      item.snooze_minutes = req_snooze_minutes;
   end

   assign req_stall  = (count_ff == 2'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head       = queue_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + 2'(push) - 2'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== rtl/rtcas_back.sv =====
module rtcas_back #(
   parameter int TICK_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  rtcas_pkg::item_type  head,
   output logic                 pop,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [16:0]          csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rtcas_pkg::result_type rsp
);
   import rtcas_pkg::*;

   localparam int CW = (TICK_WIDTH + 1 > 17) ? TICK_WIDTH + 1 : 17;

   typedef enum logic {ST_RUN, ST_SET} state_type;

   state_type             state_ff, state_in;
   logic [15:0]           tps_ff, tps_in;
   logic [16:0]           alarm_ff, alarm_in;
   logic                  enable_ff, enable_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [16:0]           sec_ff, sec_in;
   logic [4:0]            hour_ff, hour_in;
   logic [5:0]            minute_ff, minute_in;
   logic [5:0]            second_ff, second_in;
   logic                  valid_ff, valid_in;
   logic                  pending_ff, pending_in;
   logic [16:0]           target_ff, target_in;
   logic [4:0]            set_h_ff, set_h_in;
   logic [5:0]            set_m_ff, set_m_in;
   logic [5:0]            set_s_ff, set_s_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;

   logic          slot_free, load, fired;
   logic [CW-1:0] tick_next, period;
   logic          tick_wrap;
   logic [16:0]   sec_adv;
   logic [4:0]    hour_adv;
   logic [5:0]    minute_adv, second_adv;
   logic          hit;
   logic [16:0]   snz_sum, snz_target;
   logic          s_ge, m_ge;
   logic [6:0]    m_carry;
   logic [5:0]    h_carry;
   logic [16:0]   sec_set;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Prescaler; a period of zero acts as one
   always_comb begin
      tick_next = CW'(tick_ff) + CW'(1);
      period    = (tps_ff == 16'd0) ? CW'(1) : CW'(tps_ff);
      tick_wrap = (tick_next >= period) || tick_next[TICK_WIDTH];
   end

   // Next second, both as a count and as hours, minutes, seconds
   always_comb begin
      sec_adv    = (sec_ff == LAST_SECOND) ? 17'd0 : sec_ff + 17'd1;
      second_adv = second_ff + 6'd1;
      minute_adv = minute_ff;
      hour_adv   = hour_ff;
      if (second_ff == 6'd59) begin
         second_adv = 6'd0;
         minute_adv = minute_ff + 6'd1;
         if (minute_ff == 6'd59) begin
            minute_adv = 6'd0;
            hour_adv   = (hour_ff == 5'd23) ? 5'd0 : hour_ff + 5'd1;
         end
      end
      hit = enable_ff && ((sec_adv == alarm_ff) || (pending_ff && sec_adv == target_ff));
   end

   // Snooze target, one day wrap at most
   always_comb begin
      snz_sum    = sec_ff + 17'(head.snooze_minutes) * 17'd60;
      snz_target = (snz_sum >= SECS_PER_DAY) ? snz_sum - SECS_PER_DAY : snz_sum;
   end

   // Normalize set-time fields with carries; hours wrap once at most
   always_comb begin
      s_ge     = (head.second_raw >= 7'd60);
      set_s_in = s_ge ? 6'(head.second_raw - 7'd60) : head.second_raw[5:0];
      m_carry  = head.minute_raw + 7'(s_ge);
      m_ge     = (m_carry >= 7'd60);
      set_m_in = m_ge ? 6'(m_carry - 7'd60) : m_carry[5:0];
      h_carry  = head.hour_raw + 6'(m_ge);
      set_h_in = (h_carry >= 6'd24) ? 5'(h_carry - 6'd24) : h_carry[4:0];
      sec_set  = 17'(set_h_ff) * 17'd3600 + 17'(set_m_ff) * 17'd60 + 17'(set_s_ff);
   end

   // Register writes
   always_comb begin
      tps_in    = tps_ff;
      alarm_in  = alarm_ff;
      enable_in = enable_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TICKS:  tps_in    = csr_wdata[15:0];
            CSR_ALARM:  alarm_in  = csr_wdata;
            CSR_ENABLE: enable_in = csr_wdata[0];
            default:    ;
         endcase
      end
   end

   // Sequencer: execute the head of the queue
   always_comb begin
      state_in   = state_ff;
      tick_in    = tick_ff;
      sec_in     = sec_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      valid_in   = valid_ff;
      pending_in = pending_ff;
      target_in  = target_ff;
      pop        = 1'b0;
      load       = 1'b0;
      fired      = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (head_valid && slot_free) begin
               pop = 1'b1;
               unique case (head.op)
                  OP_TICK: begin
                     load = 1'b1;
                     if (tick_wrap) begin
                        tick_in   = '0;
                        sec_in    = sec_adv;
                        hour_in   = hour_adv;
                        minute_in = minute_adv;
                        second_in = second_adv;
                        fired     = hit;
                        if (hit) begin
                           pending_in = 1'b0;
                        end
                     end else begin
                        tick_in = tick_next[TICK_WIDTH-1:0];
                     end
                  end
                  OP_SET: begin
                     state_in = ST_SET;
                  end
                  OP_SNOOZE: begin
                     load       = 1'b1;
                     target_in  = snz_target;
                     pending_in = 1'b1;
                  end
                  OP_NOP: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_SET: begin
            if (slot_free) begin
               load      = 1'b1;
               sec_in    = sec_set;
               hour_in   = set_h_ff;
               minute_in = set_m_ff;
               second_in = set_s_ff;
               valid_in  = 1'b1;
               state_in  = ST_RUN;
            end
         end
      endcase
   end

   // Build the result and hold it while stalled
   always_comb begin
      rsp_in = rsp_ff;
      if (load) begin
         rsp_in.h_tens      = 2'(tens_of(6'(hour_in)));
         rsp_in.h_ones      = ones_of(6'(hour_in));
         rsp_in.m_tens      = tens_of(minute_in);
         rsp_in.m_ones      = ones_of(minute_in);
         rsp_in.s_tens      = tens_of(second_in);
         rsp_in.s_ones      = ones_of(second_in);
         rsp_in.time_valid  = valid_in;
         rsp_in.alarm_fired = fired;
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         tps_ff       <= TICKS_RESET;
         alarm_ff     <= 17'd0;
         enable_ff    <= 1'b0;
         tick_ff      <= '0;
         sec_ff       <= 17'd0;
         hour_ff      <= 5'd0;
         minute_ff    <= 6'd0;
         second_ff    <= 6'd0;
         valid_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         target_ff    <= 17'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tps_ff       <= tps_in;
         alarm_ff     <= alarm_in;
         enable_ff    <= enable_in;
         tick_ff      <= tick_in;
         sec_ff       <= sec_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         valid_ff     <= valid_in;
         pending_ff   <= pending_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop && head.op == OP_SET) begin
         set_h_ff <= set_h_in;
         set_m_ff <= set_m_in;
         set_s_ff <= set_s_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/rtc_alarm_snooze.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  cmd, six set-time digits, snooze_minutes
// rsp       out        rsp_valid/rsp_stall  six time digits, time_valid, alarm_fired
// csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Tick, snooze and no-op items are executed as they are popped; a set-time item passes
// through ST_SET, as its normalized fields are registered before the time is loaded.
// Every request is registered in a queue entry on its way from req to rsp.
// Synchronous reset clears the queue, the result valid flag, the clock state and
// restores register defaults (1000 ticks per second, alarm at midnight, disabled).
// rsp_stall holds the result register; the two-entry queue keeps taking transfers
// until it is full, and only then raises req_stall.
module rtc_alarm_snooze #(
   parameter int TICK_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [1:0]  req_set_hour_tens,
   input  logic [3:0]  req_set_hour_ones,
   input  logic [2:0]  req_set_minute_tens,
   input  logic [3:0]  req_set_minute_ones,
   input  logic [2:0]  req_set_second_tens,
   input  logic [3:0]  req_set_second_ones,
   input  logic [7:0]  req_snooze_minutes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_hour_tens,
   output logic [3:0]  rsp_hour_ones,
   output logic [2:0]  rsp_minute_tens,
   output logic [3:0]  rsp_minute_ones,
   output logic [2:0]  rsp_second_tens,
   output logic [3:0]  rsp_second_ones,
   output logic        rsp_time_valid,
   output logic        rsp_alarm_fired,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import rtcas_pkg::*;

   logic       head_valid;
   item_type   head;
   logic       pop;
   result_type rsp;

   // Registers accept a write in any cycle
   assign csr_ready = 1'b1;

   rtcas_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_set_hour_tens   (req_set_hour_tens),
      .req_set_hour_ones   (req_set_hour_ones),
      .req_set_minute_tens (req_set_minute_tens),
      .req_set_minute_ones (req_set_minute_ones),
      .req_set_second_tens (req_set_second_tens),
      .req_set_second_ones (req_set_second_ones),
      .req_snooze_minutes  (req_snooze_minutes),
      .head_valid          (head_valid),
      .head                (head),
      .pop                 (pop)
   );

   rtcas_back #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // Unpack the result onto its ports
   assign rsp_hour_tens   = rsp.h_tens;
   assign rsp_hour_ones   = rsp.h_ones;
   assign rsp_minute_tens = rsp.m_tens;
   assign rsp_minute_ones = rsp.m_ones;
   assign rsp_second_tens = rsp.s_tens;
   assign rsp_second_ones = rsp.s_ones;
   assign rsp_time_valid  = rsp.time_valid;
   assign rsp_alarm_fired = rsp.alarm_fired;

endmodule

// ===== rtl/rtcas_checker.sv =====
`include "rtc_alarm_snooze_defines.svh"

module rtcas_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_hour_tens,
   input logic [3:0] rsp_hour_ones,
   input logic [2:0] rsp_minute_tens,
   input logic [3:0] rsp_minute_ones,
   input logic [2:0] rsp_second_tens,
   input logic [3:0] rsp_second_ones,
   input logic       rsp_time_valid
);

   logic seen_ff, seen_in;
   logic digits_ok;

   // Remember that a set time has been shown since reset
   assign seen_in = seen_ff || (rsp_valid && rsp_time_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // Every digit within its clock range, hours no later than 23
   assign digits_ok = rsp_hour_tens <= 2'd2 && rsp_hour_ones <= 4'd9 &&
                      (rsp_hour_tens != 2'd2 || rsp_hour_ones <= 4'd3) &&
                      rsp_minute_tens <= 3'd5 && rsp_minute_ones <= 4'd9 &&
                      rsp_second_tens <= 3'd5 && rsp_second_ones <= 4'd9;

   `RTCAS_ASSERT_NEXT(a_hold_valid, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   `RTCAS_ASSERT_RESET(a_reset_idle, !rsp_valid, "rsp valid right after reset")

   `RTCAS_ASSERT_NOW(a_digit_range, rsp_valid, digits_ok, "time digits out of range")

   `RTCAS_ASSERT_NOW(a_valid_sticky, rsp_valid && seen_ff, rsp_time_valid, "time_valid fell")

endmodule

bind rtc_alarm_snooze rtcas_checker u_checker (.*);

// ===== bench/rtc_alarm_snooze_tb.sv =====
module rtc_alarm_snooze_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtcas_pkg::*;

   localparam int TICK_WIDTH = 16;
   localparam longint unsigned TICK_MASK = (64'd1 << TICK_WIDTH) - 64'd1;
   localparam int unsigned DAY_SECONDS = 86400;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 10;

   // One command as it is offered on the req channel
   typedef struct {
      op_type     cmd;
      logic [1:0] h_tens;
      logic [3:0] h_ones;
      logic [2:0] m_tens;
      logic [3:0] m_ones;
      logic [2:0] s_tens;
      logic [3:0] s_ones;
      logic [7:0] snooze_minutes;
   } clock_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [1:0]  req_set_hour_tens = '0;
   logic [3:0]  req_set_hour_ones = '0;
   logic [2:0]  req_set_minute_tens = '0;
   logic [3:0]  req_set_minute_ones = '0;
   logic [2:0]  req_set_second_tens = '0;
   logic [3:0]  req_set_second_ones = '0;
   logic [7:0]  req_snooze_minutes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_hour_tens;
   logic [3:0]  rsp_hour_ones;
   logic [2:0]  rsp_minute_tens;
   logic [3:0]  rsp_minute_ones;
   logic [2:0]  rsp_second_tens;
   logic [3:0]  rsp_second_ones;
   logic        rsp_time_valid;
   logic        rsp_alarm_fired;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   // Predicted clock state and register copies
   logic [TICK_WIDTH-1:0] tick_count = '0;
   logic [16:0] seconds_now = '0;
   logic        time_set = 1'b0;
   logic        snooze_armed = 1'b0;
   logic [16:0] snooze_at = '0;
   logic [15:0] ticks_per_sec = TICKS_RESET;
   logic [16:0] alarm_at = '0;
   logic        alarm_on = 1'b0;

   clock_cmd_type pending_cmds[$];
   result_type expected_times[$];
   int  queued_count = 0;
   int  checked_count = 0;
   int  mismatches = 0;
   int  cycle = 0;
   logic req_taken = 1'b0;
   logic calm;
   int  hold_left = 0;
   int  holds_done = 0;

   rtc_alarm_snooze #(.TICK_WIDTH(TICK_WIDTH)) DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) cycle <= cycle + 1;

   // No idling on either side inside this window
   assign calm = (cycle >= 1500) && (cycle < 2300);

   // Advance the predicted clock by one command and return the result it shows
   function automatic result_type clock_step(clock_cmd_type c);
      result_type r;
      longint unsigned nxt;
      longint unsigned per;
      int unsigned h, m, s;
      logic fired;
      fired = 1'b0;
      case (c.cmd)
         OP_TICK: begin
            nxt = longint'(tick_count) + 1;
            per = (ticks_per_sec == 0) ? 1 : ticks_per_sec;
            if (nxt < per && nxt <= TICK_MASK) begin
               tick_count = nxt[TICK_WIDTH-1:0];
            end else begin
               tick_count = '0;
               if (seconds_now >= LAST_SECOND) seconds_now = '0;
               else seconds_now = seconds_now + 17'd1;
               if (alarm_on) begin
                  fired = (seconds_now == alarm_at) ||
                          (snooze_armed && seconds_now == snooze_at);
                  if (fired) snooze_armed = 1'b0;
               end
            end
         end
         OP_SET: begin
            h = 10 * int'(c.h_tens) + int'(c.h_ones);
            m = 10 * int'(c.m_tens) + int'(c.m_ones);
            s = 10 * int'(c.s_tens) + int'(c.s_ones);
            seconds_now = 17'((h * 3600 + m * 60 + s) % DAY_SECONDS);
            time_set = 1'b1;
         end
         OP_SNOOZE: begin
            snooze_at = 17'((int'(seconds_now) + int'(c.snooze_minutes) * 60) % DAY_SECONDS);
            snooze_armed = 1'b1;
         end
         default: ;
      endcase
      h = seconds_now / 3600;
      m = (seconds_now % 3600) / 60;
      s = seconds_now % 60;
      r.h_tens      = 2'(h / 10);
      r.h_ones      = 4'(h % 10);
      r.m_tens      = 3'(m / 10);
      r.m_ones      = 4'(m % 10);
      r.s_tens      = 3'(s / 10);
      r.s_ones      = 4'(s % 10);
      r.time_valid  = time_set;
      r.alarm_fired = fired;
      return r;
   endfunction

   function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Predict on every req transfer, check every rsp transfer, track csr writes
   always @(posedge clock) begin
      clock_cmd_type seen;
      result_type got;
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICKS:  ticks_per_sec = csr_wdata[15:0];
               CSR_ALARM:  alarm_at = csr_wdata;
               CSR_ENABLE: alarm_on = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            seen.cmd            = op_type'(req_cmd);
            seen.h_tens         = req_set_hour_tens;
            seen.h_ones         = req_set_hour_ones;
            seen.m_tens         = req_set_minute_tens;
            seen.m_ones         = req_set_minute_ones;
            seen.s_tens         = req_set_second_tens;
            seen.s_ones         = req_set_second_ones;
            seen.snooze_minutes = req_snooze_minutes;
            expected_times.push_back(clock_step(seen));
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_hour_tens, rsp_hour_ones, rsp_minute_tens, rsp_minute_ones,
                    rsp_second_tens, rsp_second_ones, rsp_time_valid, rsp_alarm_fired};
            if (expected_times.size() == 0) begin
               $display("%0t: result transfer with no expected result, actual %p",
                        $time, got);
               mismatches++;
            end else begin
               want = expected_times.pop_front();
               check_field("h_tens", want.h_tens, got.h_tens);
               check_field("h_ones", want.h_ones, got.h_ones);
               check_field("m_tens", want.m_tens, got.m_tens);
               check_field("m_ones", want.m_ones, got.m_ones);
               check_field("s_tens", want.s_tens, got.s_tens);
               check_field("s_ones", want.s_ones, got.s_ones);
               check_field("time_valid", want.time_valid, got.time_valid);
               check_field("alarm_fired", want.alarm_fired, got.alarm_fired);
               checked_count++;
            end
         end
         req_taken <= req_valid && !req_stall;
      end
   end

   // Request driver: hold a stalled transfer, otherwise offer the next command
   always @(negedge clock) begin
      clock_cmd_type c;
      if (req_valid && !req_taken) begin
         // hold
      end else if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
         c = pending_cmds.pop_front();
         req_valid           <= 1'b1;
         req_cmd             <= c.cmd;
         req_set_hour_tens   <= c.h_tens;
         req_set_hour_ones   <= c.h_ones;
         req_set_minute_tens <= c.m_tens;
         req_set_minute_ones <= c.m_ones;
         req_set_second_tens <= c.s_tens;
         req_set_second_ones <= c.s_ones;
         req_snooze_minutes  <= c.snooze_minutes;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver: random stalls, plus long hold-offs while commands pile up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!reset && holds_done < 2 && cycle > 400 && pending_cmds.size() > 40) begin
         rsp_stall <= 1'b1;
         hold_left = 80;
         holds_done++;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 21);
      end
   end

   function automatic clock_cmd_type rand_cmd(op_type op);
      clock_cmd_type c;
      c.cmd            = op;
      c.h_tens         = 2'($urandom_range(0, 3));
      c.h_ones         = 4'($urandom_range(0, 15));
      c.m_tens         = 3'($urandom_range(0, 7));
      c.m_ones         = 4'($urandom_range(0, 15));
      c.s_tens         = 3'($urandom_range(0, 7));
      c.s_ones         = 4'($urandom_range(0, 15));
      c.snooze_minutes = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic void queue_cmd(clock_cmd_type c);
      pending_cmds.push_back(c);
      queued_count++;
   endfunction

   function automatic void push_set_time(int unsigned t);
      clock_cmd_type c;
      c = rand_cmd(OP_SET);
      c.h_tens = 2'((t / 3600) / 10);
      c.h_ones = 4'((t / 3600) % 10);
      c.m_tens = 3'(((t % 3600) / 60) / 10);
      c.m_ones = 4'(((t % 3600) / 60) % 10);
      c.s_tens = 3'((t % 60) / 10);
      c.s_ones = 4'((t % 60) % 10);
      queue_cmd(c);
   endfunction

   function automatic void push_snooze(int unsigned minutes);
      clock_cmd_type c;
      c = rand_cmd(OP_SNOOZE);
      c.snooze_minutes = 8'(minutes);
      queue_cmd(c);
   endfunction

   function automatic void push_ticks(int n);
      repeat (n) queue_cmd(rand_cmd(OP_TICK));
   endfunction

   // Mostly set-near-alarm-then-tick runs, some snooze runs, the rest noise
   task automatic gen_phase(int n, int unsigned alarm_sec, int unsigned per);
      int made;
      int pick;
      int k;
      int nt;
      int unsigned t;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            k = $urandom_range(1, 4);
            t = (alarm_sec < DAY_SECONDS) ? (alarm_sec + DAY_SECONDS - k) % DAY_SECONDS
                                          : $urandom_range(0, DAY_SECONDS - 1);
            push_set_time(t);
            made++;
            if ($urandom_range(0, 2) == 0) begin
               push_snooze($urandom_range(0, 1));
               made++;
            end
            nt = (per <= 4) ? k * per + $urandom_range(0, 2) : $urandom_range(1, 6);
            push_ticks(nt);
            made += nt;
         end else if (pick < 63 && per <= 2) begin
            push_set_time($urandom_range(0, DAY_SECONDS - 1));
            push_snooze(1);
            nt = 60 * per + $urandom_range(0, 2);
            push_ticks(nt);
            made += nt + 2;
         end else begin
            nt = $urandom_range(1, 3);
            repeat (nt) queue_cmd(rand_cmd(op_type'($urandom_range(0, 3))));
            made += nt;
         end
      end
   endtask

   // Wait until every queued command has its result checked, then let it settle
   task automatic drain();
      while (checked_count != queued_count) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [16:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(logic [16:0] ticks, logic [16:0] alarm, logic enable);
      write_reg(CSR_TICKS, ticks);
      write_reg(CSR_ALARM, alarm);
      write_reg(CSR_ENABLE, {16'($urandom_range(0, 65535)), enable});
   endtask

   // Run watchdog
   initial begin
      while (cycle < CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      clock_cmd_type c;
      logic [16:0] alarm_pick;
      logic [16:0] ticks_pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: slow prescaler, alarm off, time not yet valid
      push_ticks(2);
      queue_cmd(rand_cmd(OP_NOP));
      drain();

      // Every tick advances a second; alarm one second after midnight
      set_regs(17'd0, 17'd1, 1'b1);
      push_ticks(1);                     // fires while the time is not valid
      push_set_time(DAY_SECONDS - 1);
      push_ticks(2);                     // wrap to midnight, then fire
      c = rand_cmd(OP_SET);
      c.h_tens = 2'd3;  c.h_ones = 4'd15;
      c.m_tens = 3'd7;  c.m_ones = 4'd15;
      c.s_tens = 3'd7;  c.s_ones = 4'd15;
      queue_cmd(c);                      // digits out of range wrap modulo a day
      push_set_time(0);
      push_snooze(0);
      push_ticks(1);                     // alarm hit also clears the snooze
      push_snooze(255);
      c = rand_cmd(OP_NOP);
      c.h_tens = '1;  c.h_ones = '1;  c.m_tens = '1; c.m_ones = '1;
      c.s_tens = '1;  c.s_ones = '1;  c.snooze_minutes = '1;
      queue_cmd(c);
      push_set_time(0);
      push_snooze(0);
      push_ticks(2);
      drain();

      alarm_pick = 17'($urandom_range(0, DAY_SECONDS - 1));
      set_regs(17'd0, alarm_pick, 1'b1);
      gen_phase(240, alarm_pick, 1);
      drain();

      // Widest period and an alarm past the end of the day
      set_regs(17'h0FFFF, 17'h1FFFF, 1'b1);
      gen_phase(150, 17'h1FFFF, 65535);
      drain();

      // Lower the period below the accumulated count; alarm at midnight
      set_regs(17'h10001, 17'd0, 1'b1);
      gen_phase(200, 0, 1);
      drain();

      // Alarm disabled, snooze still armed
      set_regs(17'd3, LAST_SECOND, 1'b0);
      gen_phase(200, LAST_SECOND, 3);
      drain();

      alarm_pick = 17'($urandom_range(0, DAY_SECONDS - 1));
      set_regs(17'd2, alarm_pick, 1'b1);
      gen_phase(200, alarm_pick, 2);
      drain();

      ticks_pick = {1'($urandom_range(0, 1)), 16'($urandom_range(0, 3))};
      alarm_pick = 17'($urandom_range(0, DAY_SECONDS - 1));
      set_regs(ticks_pick, alarm_pick, 1'b1);
      gen_phase(150, alarm_pick, (ticks_pick[15:0] == 0) ? 1 : ticks_pick[15:0]);
      drain();

      if (expected_times.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_times.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
